>>> hdl/mebs_pkg.sv
`default_nettype none

package mebs_pkg;

  // field widths
  localparam int unsigned DIST_W     = 9;
  localparam int unsigned MOVE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LEFT_RUN_W = 3;

  // defaults
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [DIST_W-1:0] SIDE_OPEN_RST   = DIST_W'(15);
  localparam logic [DIST_W-1:0] FRONT_OPEN_RST  = DIST_W'(15);
  localparam logic [DIST_W-1:0] TOO_CLOSE_RST   = DIST_W'(5);
  localparam logic [DIST_W-1:0] FRONT_CLEAR_RST = DIST_W'(12);

  localparam logic [LEFT_RUN_W-1:0] LEFT_RUN_DONE = LEFT_RUN_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE_OPEN   = 2'd0,
    CFG_FRONT_OPEN  = 2'd1,
    CFG_TOO_CLOSE   = 2'd2,
    CFG_FRONT_CLEAR = 2'd3
  } cfg_idx_e;

  typedef enum logic [MOVE_W-1:0] {
    MOVE_FWD    = 3'd0,
    MOVE_LEFT   = 3'd1,
    MOVE_RIGHT  = 3'd2,
    MOVE_AROUND = 3'd3,
    MOVE_DONE   = 3'd4
  } move_e;

  typedef enum logic [1:0] {
    TAKEN_NONE     = 2'd0,
    TAKEN_STRAIGHT = 2'd1,
    TAKEN_RIGHT    = 2'd2,
    TAKEN_LEFT     = 2'd3
  } taken_e;

  // turns still to be tried at an intersection
  typedef struct packed {
    logic right;
    logic straight;
  } pend_t;

  typedef struct packed {
    taken_e taken;
    pend_t  pend;
  } stk_entry_t;

  // classified word handed from front to back
  typedef struct packed {
    logic left_open;
    logic straight_open;
    logic right_open;
    logic front_clear;
  } cls_t;

endpackage

`default_nettype wire

>>> hdl/maze_explore_backtrack_step.sv
// maze explorer step: each input word carries left, front and right wall
// distances in cm, and each yields one output word with the move, a stack
// fault flag and the number of intersections on the stack. one word is taken
// and one delivered per clock cycle unless the output stalls; the accepting
// edge writes the classify queue, and the back end loads the output register
// as it takes the word. the rate is set by the back end, which reads the top
// stack entry from a registered port addressed by the next stack level, so a
// push or pop in one cycle is seen by the word in the next. the user must
// have the thresholds written through the cfg port only while no word is in
// flight; the block does not enforce it. no clearing pass is run after reset.
`default_nettype none

module maze_explore_backtrack_step #(
  parameter int unsigned STACK_DEPTH = mebs_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LW          = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [mebs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mebs_pkg::DIST_W-1:0]    cfg_data_i,
  // input words
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [mebs_pkg::DIST_W-1:0]    left_cm_i,
  input  wire logic [mebs_pkg::DIST_W-1:0]    front_cm_i,
  input  wire logic [mebs_pkg::DIST_W-1:0]    right_cm_i,
  // output words
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [mebs_pkg::MOVE_W-1:0]         move_o,
  output logic                                stack_fault_o,
  output logic [LW-1:0]                       stack_level_o
);
  import mebs_pkg::*;

  cls_t cls_in, cls_out;
  logic q_valid, q_ready;

  // front: threshold registers and open/closed classification
  mebs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .left_cm_i  (left_cm_i),
    .front_cm_i (front_cm_i),
    .right_cm_i (right_cm_i),
    .cls_o      (cls_in)
  );

  // short queue decoupling classification from the stack engine
  mebs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (cls_in),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (cls_out)
  );

  // back: explore / backtrack state, intersection stack, output register
  mebs_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .LW          (LW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cls_valid_i   (q_valid),
    .cls_ready_o   (q_ready),
    .cls_i         (cls_out),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .move_o        (move_o),
    .stack_fault_o (stack_fault_o),
    .stack_level_o (stack_level_o)
  );

endmodule

`default_nettype wire

>>> hdl/mebs_front.sv
`default_nettype none

module mebs_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mebs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mebs_pkg::DIST_W-1:0]  cfg_data_i,
  input  wire logic [mebs_pkg::DIST_W-1:0]  left_cm_i,
  input  wire logic [mebs_pkg::DIST_W-1:0]  front_cm_i,
  input  wire logic [mebs_pkg::DIST_W-1:0]  right_cm_i,
  output mebs_pkg::cls_t                    cls_o
);
  import mebs_pkg::*;

  logic [DIST_W-1:0] side_open_q, front_open_q, too_close_q, front_clear_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_open_q   <= SIDE_OPEN_RST;
      front_open_q  <= FRONT_OPEN_RST;
      too_close_q   <= TOO_CLOSE_RST;
      front_clear_q <= FRONT_CLEAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIDE_OPEN:   side_open_q   <= cfg_data_i;
        CFG_FRONT_OPEN:  front_open_q  <= cfg_data_i;
        CFG_TOO_CLOSE:   too_close_q   <= cfg_data_i;
        CFG_FRONT_CLEAR: front_clear_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // open above threshold, or below the too-close threshold; front clear only above its threshold
  always_comb begin
    cls_o.left_open     = (left_cm_i > side_open_q) || (left_cm_i < too_close_q);
    cls_o.straight_open = (front_cm_i > front_open_q) || (front_cm_i < too_close_q);
    cls_o.right_open    = (right_cm_i > side_open_q) || (right_cm_i < too_close_q);
    cls_o.front_clear   = front_cm_i > front_clear_q;
  end

endmodule

`default_nettype wire

>>> hdl/mebs_queue.sv
`default_nettype none

module mebs_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire mebs_pkg::cls_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output mebs_pkg::cls_t      pop_data_o
);
  import mebs_pkg::*;

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);

  cls_t           slot_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign push_ready_o = cnt_q != CW'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

>>> hdl/mebs_back.sv
`default_nettype none

module mebs_back #(
  parameter int unsigned STACK_DEPTH = mebs_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LW          = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cls_valid_i,
  output logic                           cls_ready_o,
  input  wire mebs_pkg::cls_t            cls_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [mebs_pkg::MOVE_W-1:0]    move_o,
  output logic                           stack_fault_o,
  output logic [LW-1:0]                  stack_level_o
);
  import mebs_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic                  bt_q, bt_d;
  logic                  fin_q, fin_d;
  logic [LEFT_RUN_W-1:0] run_q, run_d;
  logic [LW-1:0]         top_q, top_d, top_m1, rd_lvl;

  stk_entry_t            stk_mem [STACK_DEPTH];
  stk_entry_t            rd_q;
  stk_entry_t            wr_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr, rd_addr;

  logic                  adv;
  move_e                 mv;
  logic                  fault;

  logic                  out_valid_q;
  logic [MOVE_W-1:0]     move_q;
  logic                  fault_q;
  logic [LW-1:0]         level_q;

  assign adv         = cls_valid_i && (!out_valid_q || out_ready_i);
  assign cls_ready_o = adv;
  assign top_m1      = top_q - 1'b1;

  always_comb begin
    bt_d    = bt_q;
    fin_d   = fin_q;
    run_d   = run_q;
    top_d   = top_q;
    mv      = MOVE_FWD;
    fault   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = top_q[AW-1:0];
    wr_data = '{taken: TAKEN_NONE, pend: '0};
    if (adv) begin
      if (fin_q || run_q >= LEFT_RUN_DONE) begin
        fin_d = 1'b1;
        mv    = MOVE_DONE;
      end else if (!bt_q) begin
        if (cls_i.left_open) begin
          mv = MOVE_LEFT;
          if (run_q < LEFT_RUN_DONE) run_d = run_q + 1'b1;
          wr_data = '{taken: TAKEN_LEFT,
                      pend: '{right: cls_i.right_open, straight: cls_i.straight_open}};
        end else if (cls_i.right_open) begin
          mv      = MOVE_RIGHT;
          run_d   = '0;
          wr_data = '{taken: TAKEN_RIGHT, pend: '{right: 1'b0, straight: cls_i.straight_open}};
        end else begin
          run_d = '0;
          if (cls_i.front_clear) begin
            mv = MOVE_FWD;
          end else begin
            mv   = MOVE_AROUND;
            bt_d = 1'b1;
          end
        end
        // push on a turn, dropped when full
        if (cls_i.left_open || cls_i.right_open) begin
          if (top_q == LW'(STACK_DEPTH)) begin
            fault = 1'b1;
          end else begin
            wr_en = 1'b1;
            top_d = top_q + 1'b1;
          end
        end
      end else if (cls_i.left_open || cls_i.right_open) begin
        if (top_q == '0) begin
          fault = 1'b1;
          mv    = MOVE_FWD;
        end else begin
          wr_en   = 1'b1;
          wr_addr = top_m1[AW-1:0];
          wr_data = rd_q;
          unique case (rd_q.taken)
            TAKEN_LEFT: begin
              if (rd_q.pend.right) begin
                wr_data.taken         = TAKEN_RIGHT;
                wr_data.pend.right    = 1'b0;
                bt_d                  = 1'b0;
                mv                    = MOVE_FWD;
              end else if (rd_q.pend.straight) begin
                wr_data.taken = TAKEN_STRAIGHT;
                wr_data.pend  = '0;
                bt_d          = 1'b0;
                mv            = MOVE_LEFT;
              end else begin
                wr_data.taken = TAKEN_NONE;
                mv            = MOVE_RIGHT;
              end
            end
            TAKEN_RIGHT: begin
              top_d = top_m1;
              if (rd_q.pend.straight && !rd_q.pend.right) begin
                wr_data.taken = TAKEN_STRAIGHT;
                wr_data.pend  = '0;
                bt_d          = 1'b0;
                mv            = MOVE_RIGHT;
              end else begin
                wr_data.taken = TAKEN_NONE;
                mv            = MOVE_LEFT;
              end
            end
            default: begin
              top_d         = top_m1;
              wr_data.taken = TAKEN_NONE;
              mv            = MOVE_FWD;
            end
          endcase
        end
      end else begin
        mv = MOVE_FWD;
      end
    end
  end

  // read port tracks the entry under the next top, with write forwarding
  assign rd_lvl  = top_d - 1'b1;
  assign rd_addr = rd_lvl[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) stk_mem[wr_addr] <= wr_data;
    if (wr_en && (wr_addr == rd_addr)) rd_q <= wr_data;
    else                               rd_q <= stk_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bt_q        <= 1'b0;
      fin_q       <= 1'b0;
      run_q       <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bt_q  <= bt_d;
      fin_q <= fin_d;
      run_q <= run_d;
      top_q <= top_d;
      if (adv)              out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      move_q  <= mv;
      fault_q <= fault;
      level_q <= top_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign move_o        = move_q;
  assign stack_fault_o = fault_q;
  assign stack_level_o = level_q;

endmodule

`default_nettype wire

>>> hdl/mebs_check.sv
`default_nettype none

module mebs_check #(
  parameter int unsigned STACK_DEPTH = mebs_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LW          = $clog2(STACK_DEPTH + 1)
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [mebs_pkg::MOVE_W-1:0] move_o,
  input wire logic                        stack_fault_o,
  input wire logic [LW-1:0]               stack_level_o
);
  import mebs_pkg::*;

  logic done_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && (move_o == MOVE_DONE)) begin
      done_seen_q <= 1'b1;
    end
  end

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(move_o)
      && $stable(stack_fault_o) && $stable(stack_level_o))
    else $error("output word changed while stalled");

  // once done, always done
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_seen_q |-> move_o == MOVE_DONE)
    else $error("move after done is not done");

  a_done_nofault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (move_o == MOVE_DONE) |-> !stack_fault_o)
    else $error("fault flagged on done");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> stack_level_o <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

endmodule

bind maze_explore_backtrack_step mebs_check #(
  .STACK_DEPTH (STACK_DEPTH),
  .LW          (LW)
) u_mebs_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .move_o        (move_o),
  .stack_fault_o (stack_fault_o),
  .stack_level_o (stack_level_o)
);

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

// maze explorer step: a directed walk through the stack cases, then randomised
// exploration under several threshold settings and handshake idling mixes,
// finishing with a left-turn run that drives the explorer to done
module tb_top;
  import mebs_pkg::*;

  localparam int unsigned          DEPTH        = STACK_DEPTH_DEF;
  localparam logic [DIST_W-1:0]    DIST_MAX     = '1;
  localparam int unsigned          DIR_ROWS     = 26;
  localparam int unsigned          SEGMENTS     = 6;
  localparam int unsigned          RAND_PER_SEG = 165;
  localparam int unsigned          HOLD_CYCLES  = 60;
  localparam int unsigned          QUIET_LIMIT  = 3000;
  localparam int unsigned          SHOW_ERRORS  = 10;

  // one output word as the explorer should produce it
  typedef struct packed {
    move_e      mv;
    logic       fault;
    logic [4:0] level;
  } move_word_t;

  // directed row: readings plus an optional hand-written answer
  typedef struct packed {
    logic [DIST_W-1:0] l;
    logic [DIST_W-1:0] f;
    logic [DIST_W-1:0] r;
    logic              typed;
    move_word_t        word;
  } walk_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [DIST_W-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [DIST_W-1:0]    left_cm_i   = '0;
  logic [DIST_W-1:0]    front_cm_i  = '0;
  logic [DIST_W-1:0]    right_cm_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [MOVE_W-1:0]    move_o;
  logic                 stack_fault_o;
  logic [4:0]           stack_level_o;

  maze_explore_backtrack_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .left_cm_i     (left_cm_i),
    .front_cm_i    (front_cm_i),
    .right_cm_i    (right_cm_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .move_o        (move_o),
    .stack_fault_o (stack_fault_o),
    .stack_level_o (stack_level_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // explorer shadow: thresholds, mode, left-turn run and intersection stack
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0] side_thr  = SIDE_OPEN_RST;
  logic [DIST_W-1:0] front_thr = FRONT_OPEN_RST;
  logic [DIST_W-1:0] close_thr = TOO_CLOSE_RST;
  logic [DIST_W-1:0] clear_thr = FRONT_CLEAR_RST;

  logic   retreat  = 1'b0;
  logic   is_done  = 1'b0;
  int     run_left = 0;
  int     depth_used = 0;
  taken_e taken_stk [DEPTH];
  pend_t  pend_stk  [DEPTH];

  move_word_t moves_due [$];

  // bookkeeping for the closing summary
  int errors        = 0;
  int readings_sent = 0;
  int words_checked = 0;
  int faults_seen   = 0;
  int done_seen     = 0;
  int settings_used = 1;

  // handshake idling mix, changed by the stimulus between segments
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;

  function automatic logic wall_gap(input logic [DIST_W-1:0] d, input logic [DIST_W-1:0] thr);
    return (d > thr) || (d < close_thr);
  endfunction

  // returns 1 when the stack is full and the entry is lost
  function automatic logic push_turn(input taken_e tk, input pend_t p);
    if (depth_used >= DEPTH) return 1'b1;
    taken_stk[depth_used] = tk;
    pend_stk[depth_used]  = p;
    depth_used++;
    return 1'b0;
  endfunction

  function automatic move_word_t advance_explorer(input logic [DIST_W-1:0] l, f, r);
    logic       lo, so, ro;
    pend_t      p;
    int         t;
    move_word_t w;
    lo = wall_gap(l, side_thr);
    so = wall_gap(f, front_thr);
    ro = wall_gap(r, side_thr);
    w.mv    = MOVE_FWD;
    w.fault = 1'b0;
    if (is_done || run_left >= LEFT_RUN_DONE) begin
      // latched for good, nothing else moves
      is_done = 1'b1;
      w.mv    = MOVE_DONE;
    end else if (!retreat) begin
      if (lo) begin
        w.mv = MOVE_LEFT;
        if (run_left < LEFT_RUN_DONE) run_left++;
        p.right    = ro;
        p.straight = so;
        w.fault = push_turn(TAKEN_LEFT, p);
      end else if (ro) begin
        w.mv     = MOVE_RIGHT;
        run_left = 0;
        p.right    = 1'b0;
        p.straight = so;
        w.fault = push_turn(TAKEN_RIGHT, p);
      end else begin
        run_left = 0;
        if (f > clear_thr) begin
          w.mv = MOVE_FWD;
        end else begin
          w.mv    = MOVE_AROUND;
          retreat = 1'b1;
        end
      end
    end else if (lo || ro) begin
      if (depth_used == 0) begin
        // pop refused, stays retreating
        w.fault = 1'b1;
      end else begin
        t = depth_used - 1;
        case (taken_stk[t])
          TAKEN_LEFT: begin
            if (pend_stk[t].right) begin
              taken_stk[t]      = TAKEN_RIGHT;
              pend_stk[t].right = 1'b0;
              retreat = 1'b0;
              w.mv    = MOVE_FWD;
            end else if (pend_stk[t].straight) begin
              taken_stk[t] = TAKEN_STRAIGHT;
              pend_stk[t]  = '0;
              retreat = 1'b0;
              w.mv    = MOVE_LEFT;
            end else begin
              taken_stk[t] = TAKEN_NONE;
              w.mv = MOVE_RIGHT;
            end
          end
          TAKEN_RIGHT: begin
            // a right branch is popped whether straight is left or not
            depth_used = t;
            if (pend_stk[t].straight && !pend_stk[t].right) begin
              taken_stk[t] = TAKEN_STRAIGHT;
              pend_stk[t]  = '0;
              retreat = 1'b0;
              w.mv    = MOVE_RIGHT;
            end else begin
              taken_stk[t] = TAKEN_NONE;
              w.mv = MOVE_LEFT;
            end
          end
          default: begin
            depth_used   = t;
            taken_stk[t] = TAKEN_NONE;
            w.mv = MOVE_FWD;
          end
        endcase
      end
    end
    w.level = 5'(depth_used);
    return w;
  endfunction

  // true when retreating would reach an entry that sends the explorer onwards
  function automatic logic can_resume();
    for (int i = 0; i < depth_used; i++) begin
      if (taken_stk[i] == TAKEN_LEFT && (pend_stk[i].right || pend_stk[i].straight)) return 1'b1;
      if (taken_stk[i] == TAKEN_RIGHT && pend_stk[i].straight) return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // reading generators, biased towards the threshold edges
  // ---------------------------------------------------------------------------
  function automatic logic [DIST_W-1:0] closed_dist(input logic [DIST_W-1:0] thr);
    if (close_thr > thr) return DIST_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return close_thr;
      1:       return thr;
      default: return DIST_W'($urandom_range(int'(close_thr), int'(thr)));
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] open_dist(input logic [DIST_W-1:0] thr);
    if (thr != DIST_MAX && (close_thr == '0 || $urandom_range(0, 2) != 0)) begin
      if ($urandom_range(0, 3) == 0) return thr + 1'b1;
      return DIST_W'($urandom_range(int'(thr) + 1, int'(DIST_MAX)));
    end
    if (close_thr != '0) begin
      if ($urandom_range(0, 3) == 0) return close_thr - 1'b1;
      return DIST_W'($urandom_range(0, int'(close_thr) - 1));
    end
    return DIST_W'($urandom);
  endfunction

  function automatic logic [DIST_W-1:0] any_side();
    return $urandom_range(0, 1) ? open_dist(side_thr) : closed_dist(side_thr);
  endfunction

  // mostly well-formed moves for the current mode, a tenth pure noise;
  // the explorer is kept away from done and from a retreat with no way out
  function automatic void pick_reading(output logic [DIST_W-1:0] l, f, r);
    int dice;
    dice = $urandom_range(0, 99);
    f = $urandom_range(0, 1) ? open_dist(front_thr) : closed_dist(front_thr);
    l = any_side();
    r = any_side();
    if (retreat) begin
      if (dice < 10) begin
        l = DIST_W'($urandom);
        f = DIST_W'($urandom);
        r = DIST_W'($urandom);
      end else if (dice < 40) begin
        // corridor while retreating
        l = closed_dist(side_thr);
        r = closed_dist(side_thr);
      end else begin
        case ($urandom_range(0, 2))
          0:       begin l = open_dist(side_thr);   r = closed_dist(side_thr); end
          1:       begin l = closed_dist(side_thr); r = open_dist(side_thr);   end
          default: begin l = open_dist(side_thr);   r = open_dist(side_thr);   end
        endcase
      end
    end else begin
      if (dice < 10) begin
        l = DIST_W'($urandom);
        f = DIST_W'($urandom);
        r = DIST_W'($urandom);
      end else if (dice < 45) begin
        l = open_dist(side_thr);
      end else if (dice < 78) begin
        l = closed_dist(side_thr);
        r = open_dist(side_thr);
      end else begin
        l = closed_dist(side_thr);
        r = closed_dist(side_thr);
        if (dice < 88 && clear_thr != DIST_MAX) begin
          f = ($urandom_range(0, 3) == 0) ? clear_thr + 1'b1 :
              DIST_W'($urandom_range(int'(clear_thr) + 1, int'(DIST_MAX)));
        end else begin
          f = ($urandom_range(0, 3) == 0) ? clear_thr :
              DIST_W'($urandom_range(0, int'(clear_thr)));
        end
      end
      if (run_left == LEFT_RUN_DONE - 1 && wall_gap(l, side_thr)) l = closed_dist(side_thr);
      if (!wall_gap(l, side_thr) && !wall_gap(r, side_thr) && f <= clear_thr && !can_resume())
        r = open_dist(side_thr);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic offer_reading(input logic [DIST_W-1:0] l, f, r, input logic typed,
                               input move_word_t typed_word);
    move_word_t w;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_cm_i  <= l;
    front_cm_i <= f;
    right_cm_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    w = advance_explorer(l, f, r);
    moves_due.push_back(typed ? typed_word : w);
    readings_sent++;
  endtask

  // stop offering and wait for every outstanding move word
  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (moves_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DIST_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    case (idx)
      CFG_SIDE_OPEN:  side_thr  = v;
      CFG_FRONT_OPEN: front_thr = v;
      CFG_TOO_CLOSE:  close_thr = v;
      default:        clear_thr = v;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_thresholds(input logic [DIST_W-1:0] side, front, close, clear);
    write_reg(CFG_SIDE_OPEN, side);
    write_reg(CFG_FRONT_OPEN, front);
    write_reg(CFG_TOO_CLOSE, close);
    write_reg(CFG_FRONT_CLEAR, clear);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    walk_row_t         walk_tab [DIR_ROWS];
    logic [DIST_W-1:0] l, f, r;
    logic [DIST_W-1:0] side, close;

    // default thresholds: side 15, front 15, too close 5, front clear 12
    walk_tab = '{
      '{9'd20,  9'd20,  9'd20,  1'b1, '{MOVE_LEFT,   1'b0, 5'd1}}, // first word after reset
      '{9'd10,  9'd10,  9'd20,  1'b1, '{MOVE_RIGHT,  1'b0, 5'd2}},
      '{9'd10,  9'd13,  9'd10,  1'b0, '0},                         // just clear, drive on
      '{9'd15,  9'd12,  9'd15,  1'b1, '{MOVE_AROUND, 1'b0, 5'd2}}, // every reading on its edge
      '{9'd5,   9'd0,   9'd5,   1'b0, '0},                         // corridor while retreating
      '{9'd4,   9'd10,  9'd10,  1'b0, '0},                         // right branch fully done
      '{9'd0,   9'd0,   9'd0,   1'b0, '0},                         // right still pending
      '{9'd10,  9'd0,   9'd10,  1'b0, '0},
      '{9'd511, 9'd511, 9'd511, 1'b1, '{MOVE_RIGHT,  1'b0, 5'd0}}, // right branch, straight left
      '{9'd511, 9'd0,   9'd0,   1'b0, '0},
      '{9'd16,  9'd16,  9'd16,  1'b0, '0},
      '{9'd6,   9'd6,   9'd6,   1'b0, '0},
      '{9'd14,  9'd10,  9'd4,   1'b0, '0},
      '{9'd10,  9'd10,  9'd16,  1'b0, '0},
      '{9'd10,  9'd12,  9'd10,  1'b0, '0},
      '{9'd0,   9'd10,  9'd10,  1'b0, '0},
      '{9'd0,   9'd10,  9'd10,  1'b0, '0},
      '{9'd20,  9'd20,  9'd10,  1'b0, '0},                         // left with straight only
      '{9'd10,  9'd5,   9'd10,  1'b0, '0},
      '{9'd20,  9'd10,  9'd10,  1'b0, '0},                         // resume straight
      '{9'd20,  9'd10,  9'd10,  1'b0, '0},                         // left with nothing pending
      '{9'd10,  9'd10,  9'd10,  1'b0, '0},
      '{9'd20,  9'd10,  9'd10,  1'b0, '0},                         // left branch exhausted
      '{9'd20,  9'd10,  9'd10,  1'b0, '0},                         // spent entry popped
      '{9'd20,  9'd10,  9'd10,  1'b0, '0},                         // straight entry popped
      '{9'd20,  9'd10,  9'd10,  1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // pairs of segments: slow receiver, then slow sender, then no idling
      case (seg / 2)
        0:       begin send_idle_pct = 24; recv_idle_pct = 81; end
        1:       begin send_idle_pct = 81; recv_idle_pct = 24; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase

      case (seg)
        0: begin
          for (int i = 0; i < DIR_ROWS; i++)
            offer_reading(walk_tab[i].l, walk_tab[i].f, walk_tab[i].r,
                          walk_tab[i].typed, walk_tab[i].word);
        end
        1: set_thresholds('0, DIST_MAX, '0, '0);
        2: set_thresholds(DIST_MAX, '0, DIST_MAX, DIST_MAX);
        default: begin
          // too close never above the side threshold, so a closed left exists
          side  = DIST_W'($urandom);
          close = DIST_W'($urandom_range(0, int'(side)));
          if (side == DIST_MAX && close == '0) close = 1'b1;
          set_thresholds(side, DIST_W'($urandom), close, DIST_W'($urandom));
        end
      endcase

      // long receiver stall with the sender streaming, fills the block
      if (seg == 4) hold_req = 1'b1;

      for (int k = 0; k < RAND_PER_SEG; k++) begin
        pick_reading(l, f, r);
        offer_reading(l, f, r, 1'b0, '0);
      end
      drain_words();
    end

    // back to defaults, finish any retreat, then lefts in a row until done
    set_thresholds(SIDE_OPEN_RST, FRONT_OPEN_RST, TOO_CLOSE_RST, FRONT_CLEAR_RST);
    while (retreat) offer_reading(9'd20, 9'd20, 9'd20, 1'b0, '0);
    while (!is_done) offer_reading(9'd20, 9'd20, 9'd20, 1'b0, '0);
    repeat (2) offer_reading(9'd30, 9'd3, 9'd511, 1'b0, '0);
    drain_words();
    repeat (4) @(posedge clk_i);

    $display("covered %0d readings over %0d threshold settings", readings_sent, settings_used);
    $display("checked %0d moves: %0d with a stack fault, %0d done", words_checked,
             faults_seen, done_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready, one long stall counted here
  // ---------------------------------------------------------------------------
  int unsigned hold_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req && hold_count < HOLD_CYCLES) begin
      hold_count  <= hold_count + 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted move word against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report(input string msg);
    errors++;
    if (errors <= SHOW_ERRORS) $display("%0t: %s", $time, msg);
  endtask

  move_word_t head_word;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (moves_due.size() == 0) begin
        report($sformatf("move word with none due: move %0d fault %0d level %0d",
                         move_o, stack_fault_o, stack_level_o));
      end else begin
        head_word = moves_due.pop_front();
        words_checked++;
        if (head_word.fault) faults_seen++;
        if (head_word.mv == MOVE_DONE) done_seen++;
        if (move_o !== head_word.mv || stack_fault_o !== head_word.fault ||
            stack_level_o !== head_word.level)
          report($sformatf("mismatch at word %0d: move %0d/%0d fault %0d/%0d level %0d/%0d %s",
                           words_checked, head_word.mv, move_o, head_word.fault,
                           stack_fault_o, head_word.level, stack_level_o,
                           "(expected/actual)"));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no word moving on either side
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("watchdog: %0d words still due", moves_due.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

>>> maze_explore_backtrack_step.f
hdl/mebs_pkg.sv
hdl/mebs_front.sv
hdl/mebs_queue.sv
hdl/mebs_back.sv
hdl/maze_explore_backtrack_step.sv
hdl/mebs_check.sv
test/tb_top.sv
